>>> hdl/t2r8_pkg.sv
// shared types, constants and channel conversion function for the texel to rgba8 converter
package t2r8_pkg;

  localparam int MAX_DIMENSION = 8192;
  localparam int DIM_W         = 14;
  localparam int CNT_W         = 13;
  localparam int IDX_W         = 26;
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;

  typedef enum logic [1:0] {
    FMT_HALF  = 2'd0,
    FMT_RGBA8 = 2'd1,
    FMT_BGRA8 = 2'd2
  } fmt_e;

  typedef enum logic [1:0] {
    REG_FORMAT = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_FLIP   = 2'd3
  } reg_idx_e;

  typedef logic [DIM_W-1:0] dim_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;

  function automatic dim_t eff_dim(dim_t d);
    dim_t res;
    if (d == '0) begin
      res = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIMENSION)) begin
      res = DIM_W'(MAX_DIMENSION);
    end else begin
      res = d;
    end
    return res;
  endfunction

  // clamp to [0,1], scale by 255, add one half, round to 24 bits, truncate
  function automatic logic [7:0] half_to_byte(logic [15:0] h);
    logic        sgn;
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [23:0] v;
    logic [31:0] n;
    logic [3:0]  s;
    logic [31:0] q;
    logic [31:0] r;
    logic [31:0] halfw;
    logic [32:0] m;
    logic [7:0]  res;
    sgn = h[15];
    ex  = h[14:10];
    man = h[9:0];
    if (ex == 5'h00) begin
      v = {14'd0, man};
    end else begin
      v = 24'({1'b1, man}) << (ex - 5'd1);
    end
    n = {v, 8'd0} - {8'd0, v} + 32'h0080_0000;
    s = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (n[24+i]) begin
        s = 4'(i + 1);
      end
    end
    q     = n >> s;
    r     = n & ((32'd1 << s) - 32'd1);
    halfw = (s == 4'd0) ? 32'd0 : (32'd1 << (s - 4'd1));
    if (s != 4'd0 && (r > halfw || (r == halfw && q[0]))) begin
      q = q + 32'd1;
    end
    m = {1'b0, q} << s;
    if (m[32:24] > 9'd255) begin
      res = 8'd255;
    end else begin
      res = m[31:24];
    end
    if (ex == 5'h1f && man != 10'd0) begin
      res = 8'd0;
    end else if (sgn) begin
      res = 8'd0;
    end else if (ex >= 5'd15) begin
      res = 8'd255;
    end
    return res;
  endfunction

endpackage

>>> hdl/texel_to_rgba8_converter_unit.sv
// texel to rgba8 converter: input register, channel conversion and index, result register
// Converts one source texel beat per clock, when not stalled, into the red, green and blue
// bytes of an opaque RGBA8 pixel together with its destination index and an end-of-frame
// flag. Sustained rate is one beat per cycle while out_stall_i stays low. Each beat passes
// the input register, then the result register, with the half-float rounding and the
// row-times-width multiply between them. in_stall_o follows out_stall_i only while both
// pipeline registers are full. Configure format, width, height and flip through the APB
// port while no beat is in flight.
module texel_to_rgba8_converter_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [t2r8_pkg::ADDR_W-1:0] paddr,
  input  logic [t2r8_pkg::DATA_W-1:0] pwdata,
  output logic [t2r8_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [63:0]                 texel_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  red_o,
  output logic [7:0]                  green_o,
  output logic [7:0]                  blue_o,
  output logic [t2r8_pkg::IDX_W-1:0]  dest_index_o,
  output logic                        last_texel_o
);
  import t2r8_pkg::*;

  logic [1:0] fmt_q;
  dim_t       width_q;
  dim_t       height_q;
  logic       flip_q;
  reg_idx_e   reg_sel;
  logic       cfg_wr;

  cnt_t col_q, col_d;
  cnt_t row_q, row_d;

  logic        s1_valid_q;
  logic [47:0] s1_texel_q;
  idx_t        s1_drow_q;
  cnt_t        s1_col_q;
  logic        s1_last_q;

  logic        out_valid_q;
  logic [7:0]  red_q, red_d;
  logic [7:0]  green_q, green_d;
  logic [7:0]  blue_q, blue_d;
  idx_t        dest_q, dest_d;
  logic        last_q;

  dim_t        w_eff;
  dim_t        h_eff;
  idx_t        drow;
  logic        end_row;
  logic        end_frame;
  logic        in_acc;
  logic        s1_en;
  logic        s2_en;
  logic [39:0] prod;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_RGBA8;
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
      flip_q   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_FORMAT: fmt_q    <= pwdata[1:0];
        REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
        REG_FLIP:   flip_q   <= pwdata[0];
        default:    fmt_q    <= fmt_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FORMAT: prdata = DATA_W'(fmt_q);
      REG_WIDTH:  prdata = DATA_W'(width_q);
      REG_HEIGHT: prdata = DATA_W'(height_q);
      REG_FLIP:   prdata = DATA_W'(flip_q);
      default:    prdata = '0;
    endcase
  end

  // pipeline control
  assign s2_en      = !out_valid_q || !out_stall_i;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_stall_o = !s1_en;
  assign in_acc     = in_valid_i && !in_stall_o;

  // raster counters
  assign w_eff     = eff_dim(width_q);
  assign h_eff     = eff_dim(height_q);
  assign end_row   = (DIM_W'(col_q) + DIM_W'(1)) >= w_eff;
  assign end_frame = end_row && ((DIM_W'(row_q) + DIM_W'(1)) >= h_eff);
  assign drow      = flip_q ? (IDX_W'(h_eff) - IDX_W'(1) - IDX_W'(row_q)) : IDX_W'(row_q);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (end_row) begin
        col_d = '0;
        row_d = end_frame ? '0 : row_q + CNT_W'(1);
      end else begin
        col_d = col_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_texel_q <= texel_data_i[47:0];
      s1_drow_q  <= drow;
      s1_col_q   <= col_q;
      s1_last_q  <= end_frame;
    end
  end

  // channel conversion and destination index
  always_comb begin
    red_d   = 8'd0;
    green_d = 8'd0;
    blue_d  = 8'd0;
    case (fmt_q)
      FMT_HALF: begin
        red_d   = half_to_byte(s1_texel_q[15:0]);
        green_d = half_to_byte(s1_texel_q[31:16]);
        blue_d  = half_to_byte(s1_texel_q[47:32]);
      end
      FMT_RGBA8: begin
        red_d   = s1_texel_q[7:0];
        green_d = s1_texel_q[15:8];
        blue_d  = s1_texel_q[23:16];
      end
      FMT_BGRA8: begin
        red_d   = s1_texel_q[23:16];
        green_d = s1_texel_q[15:8];
        blue_d  = s1_texel_q[7:0];
      end
      default: begin
        red_d   = 8'd0;
        green_d = 8'd0;
        blue_d  = 8'd0;
      end
    endcase
  end

  assign prod   = 40'(s1_drow_q) * 40'(w_eff);
  assign dest_d = prod[IDX_W-1:0] + IDX_W'(s1_col_q);

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_en) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_valid_q) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      dest_q  <= dest_d;
      last_q  <= s1_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_o        = red_q;
  assign green_o      = green_q;
  assign blue_o       = blue_q;
  assign dest_index_o = dest_q;
  assign last_texel_o = last_q;

  // an empty result register never holds off the input
  a_no_stall_when_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !out_valid_q |-> !in_stall_o
  ) else $error("input stalled with empty result register");

  // counters restart after the final beat of a frame
  a_frame_restart: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (in_acc && end_frame) |=> (col_q == '0 && row_q == '0)
  ) else $error("counters not cleared after end of frame");

  // a held beat moves to the result register when it is free
  a_advance: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (s1_valid_q && s2_en) |=> out_valid_q
  ) else $error("beat lost between input and result register");

  // column counter steps by one inside a row
  a_col_in_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (in_acc && !end_row) |=> (col_q == $past(col_q) + CNT_W'(1))
  ) else $error("column counter skipped");

endmodule
